FILE: design/vtpd_pkg.sv
// ============================================================================
// vtpd_pkg
// Types, constants and helper functions shared by the vertex transform files.
// ============================================================================
`default_nettype none

package vtpd_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 32;
    localparam int ENTRY_W  = 16;
    localparam int ROW_W    = 64;
    localparam int NROWS    = 4;
    localparam int PROD_W   = ENTRY_W + COORD_W;   // one matrix entry times one coordinate
    localparam int ACC_W    = PROD_W + 2;          // sum of four products
    localparam int MAG_W    = ACC_W;               // magnitude of a sum
    localparam int QUO_W    = 32;                  // quotient bits produced by the divider
    localparam int FRAC_W   = 16;                  // the numerator is scaled by 2^16
    localparam int STEP_N   = 2;                   // quotient bits resolved per divider stage
    localparam int DIV_STG  = QUO_W / STEP_N;      // divider pipeline depth

    // Homogeneous coordinate w = 1.0 in Q16.16.
    localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;

    // Saturation limits.
    localparam logic [QUO_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] NEG_MAX = 32'h8000_0000;

    // Register indexes.
    localparam logic [1:0] REG_ROW_ZERO  = 2'd0;
    localparam logic [1:0] REG_ROW_ONE   = 2'd1;
    localparam logic [1:0] REG_ROW_TWO   = 2'd2;
    localparam logic [1:0] REG_ROW_THREE = 2'd3;

    // Reset values give the identity matrix.
    localparam logic [ROW_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      w_zero;
        logic                      saturated;
    } t_out_beat;

    // Per-lane sign and overflow information that rides beside the divider.
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] big;
        logic       w_zero;
    } t_side;

    // One restoring division step: shift in one numerator bit, subtract if it fits.
    function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                                input logic [MAG_W-1:0] den,
                                                input logic             nbit);
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        logic [MAG_W:0] r;
        t = {rem, nbit};
        d = {1'b0, den};
        if (t >= d) begin
            r = t - d;
            div_step = {1'b1, r[MAG_W-1:0]};
        end else begin
            div_step = {1'b0, t[MAG_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/vtpd_divider.sv
// ============================================================================
// vtpd_divider
// Pipelined restoring divider: floor(num * 2^16 / den), low 32 quotient bits.
// ============================================================================
`default_nettype none

module vtpd_divider
    import vtpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [MAG_W-1:0] i_num,
    input  wire logic [MAG_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo
);

    logic [MAG_W-1:0] r_rem [DIV_STG];
    logic [MAG_W-1:0] r_den [DIV_STG];
    logic [QUO_W-1:0] r_quo [DIV_STG];
    logic [QUO_W-1:0] r_low [DIV_STG];

    logic [MAG_W-1:0] n_rem [DIV_STG];
    logic [QUO_W-1:0] n_quo [DIV_STG];
    logic [QUO_W-1:0] n_low [DIV_STG];

    genvar s;
    generate
        for (s = 0; s < DIV_STG; s++) begin : g_stg
            logic [MAG_W-1:0] src_rem;
            logic [MAG_W-1:0] src_den;
            logic [QUO_W-1:0] src_quo;
            logic [QUO_W-1:0] src_low;

            // The first stage starts from the numerator's upper part; the rest chain on.
            if (s == 0) begin : g_first
                assign src_rem = {{FRAC_W{1'b0}}, i_num[MAG_W-1:FRAC_W]};
                assign src_den = i_den;
                assign src_quo = '0;
                assign src_low = {i_num[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
            end else begin : g_next
                assign src_rem = r_rem[s-1];
                assign src_den = r_den[s-1];
                assign src_quo = r_quo[s-1];
                assign src_low = r_low[s-1];
            end

            // Resolve STEP_N quotient bits in this stage.
            always_comb begin
                logic [MAG_W-1:0] rem;
                logic [QUO_W-1:0] quo;
                logic [QUO_W-1:0] low;
                logic [MAG_W:0]   res;
                rem = src_rem;
                quo = src_quo;
                low = src_low;
                for (int k = 0; k < STEP_N; k++) begin
                    res = div_step(rem, src_den, low[QUO_W-1]);
                    rem = res[MAG_W-1:0];
                    quo = {quo[QUO_W-2:0], res[MAG_W]};
                    low = {low[QUO_W-2:0], 1'b0};
                end
                n_rem[s] = rem;
                n_quo[s] = quo;
                n_low[s] = low;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem[s];
                    r_den[s] <= src_den;
                    r_quo[s] <= n_quo[s];
                    r_low[s] <= n_low[s];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_STG-1];

endmodule

`default_nettype wire

FILE: design/vertex_transform_perspective_divide_top.sv
// ============================================================================
// vertex_transform_perspective_divide_top
// 4x4 homogeneous point transform followed by a saturating perspective divide.
// ============================================================================
// Usage:
//   Input beats (i_valid / o_ready / i_in) carry one Q16.16 point each. The
//   point is extended with w = 1, multiplied by the four matrix rows and x, y
//   and z are divided by w, truncated toward zero and clamped to 32 bits.
//   Output beats (o_valid / i_ready / o_out) carry the quotients, w_zero and
//   saturated.
//   Rows are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//   Throughput: one point per cycle unless the receiver stalls the output.
//   Pipeline from acceptance to o_valid: multiply, sum, sign split, 16
//   divider stages of two quotient bits each, output register.
//   Reset loads the identity matrix and empties the pipeline.
//   When the receiver stalls a full output register, the whole pipeline
//   holds and o_ready drops; no bubbles are squeezed out meanwhile, and no
//   beat is lost or repeated.
// ============================================================================
`default_nettype none

module vertex_transform_perspective_divide_top
    import vtpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [ROW_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_in_beat         i_in,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out_beat             o_out
);

    localparam int NSTG = 3 + DIV_STG + 1;

    logic [ROW_W-1:0] r_row [NROWS];
    logic [NSTG-1:0]  r_vld;
    logic             en;

    // Pipeline advances unless a finished beat waits at the output.
    assign en      = ~r_vld[NSTG-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];

    // Matrix row registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_ZERO_RST;
            r_row[1] <= ROW_ONE_RST;
            r_row[2] <= ROW_TWO_RST;
            r_row[3] <= ROW_THREE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_ZERO:  r_row[0] <= i_cfg_data;
                REG_ROW_ONE:   r_row[1] <= i_cfg_data;
                REG_ROW_TWO:   r_row[2] <= i_cfg_data;
                REG_ROW_THREE: r_row[3] <= i_cfg_data;
                default:       r_row[0] <= r_row[0];
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Stage 1: sixteen products.
    logic signed [COORD_W-1:0] op [NROWS];
    logic signed [PROD_W-1:0]  r_prod [NROWS][NROWS];

    assign op[0] = i_in.in_x;
    assign op[1] = i_in.in_y;
    assign op[2] = i_in.in_z;
    assign op[3] = ONE_Q16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < NROWS; r++) begin
                for (int c = 0; c < NROWS; c++) begin
                    r_prod[r][c] <= $signed(r_row[r][ENTRY_W*c +: ENTRY_W]) * op[c];
                end
            end
        end
    end

    // Stage 2: row sums.
    logic signed [ACC_W-1:0] r_acc [NROWS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < NROWS; r++) begin
                r_acc[r] <= ACC_W'(r_prod[r][0]) + ACC_W'(r_prod[r][1])
                          + ACC_W'(r_prod[r][2]) + ACC_W'(r_prod[r][3]);
            end
        end
    end

    // Stage 3: magnitudes, quotient signs and the overflow pre-check.
    logic [MAG_W-1:0] mag [NROWS];
    logic [MAG_W-1:0] r_num [3];
    logic [MAG_W-1:0] r_den;
    t_side            r_side;

    always_comb begin
        for (int r = 0; r < NROWS; r++) begin
            mag[r] = r_acc[r][ACC_W-1] ? MAG_W'(-r_acc[r]) : MAG_W'(r_acc[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_num[l]      <= mag[l];
                r_side.neg[l] <= r_acc[l][ACC_W-1] ^ r_acc[3][ACC_W-1];
                // A quotient of 2^32 or more saturates whatever the sign.
                r_side.big[l] <= {{FRAC_W{1'b0}}, mag[l][MAG_W-1:FRAC_W]} >= mag[3];
            end
            r_den         <= mag[3];
            r_side.w_zero <= (r_acc[3] == '0);
        end
    end

    // Dividers, one per coordinate.
    logic [QUO_W-1:0] quo [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            vtpd_divider u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_num[g]),
                .i_den (r_den),
                .o_quo (quo[g])
            );
        end
    endgenerate

    // Side information delayed to line up with the divider output.
    t_side r_sdly [DIV_STG];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdly[0] <= r_side;
            for (int s = 1; s < DIV_STG; s++) begin
                r_sdly[s] <= r_sdly[s-1];
            end
        end
    end

    // Output stage: apply sign, clamp and the zero-w rule.
    t_side            sd;
    logic [QUO_W-1:0] res [3];
    logic [2:0]       sat;
    t_out_beat        r_out;

    assign sd = r_sdly[DIV_STG-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (sd.w_zero) begin
                res[l] = '0;
                sat[l] = 1'b0;
            end else if (!sd.neg[l]) begin
                sat[l] = sd.big[l] | (quo[l] > POS_MAX);
                res[l] = sat[l] ? POS_MAX : quo[l];
            end else begin
                sat[l] = sd.big[l] | (quo[l] > NEG_MAX);
                res[l] = sat[l] ? NEG_MAX : (~quo[l] + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_x     <= res[0];
            r_out.out_y     <= res[1];
            r_out.out_z     <= res[2];
            r_out.w_zero    <= sd.w_zero;
            r_out.saturated <= |sat;
        end
    end

    assign o_out = r_out;

    // A zero w result carries zero coordinates and no saturation.
    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.w_zero |-> !o_out.saturated && o_out.out_x == '0
                                   && o_out.out_y == '0 && o_out.out_z == '0)
        else $error("w_zero result not cleared");

    // An accepted beat enters the first pipeline stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted beat lost at entry");

    // Reset restores the identity matrix.
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_row[0] == ROW_ZERO_RST && r_row[3] == ROW_THREE_RST)
        else $error("matrix rows not reset");

endmodule

`default_nettype wire

FILE: tb/sv/tb_vertex_transform_perspective_divide_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_vertex_transform_perspective_divide_top
// Self-checking bench for the homogeneous point transform and divide.
// ============================================================================
// Points are sent through the input handshake while a local model computes
// the transformed and divided coordinates. Each output beat is compared field
// by field with the oldest predicted beat. Directed tests cover identity,
// extreme coordinates, zero w, overflow in both directions and negative w.
// Random tests run under several matrices, written only while the pipeline
// is empty, with random idle cycles on both sides.
// ============================================================================

module tb_vertex_transform_perspective_divide_top;
    import vtpd_pkg::*;

    localparam int LATENCY    = 20;
    localparam int STALL_LIMIT = 2000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [ROW_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    t_in_beat         in_beat;
    logic             out_valid;
    logic             out_ready;
    t_out_beat        out_beat;

    // Local copy of the matrix rows and the queue of predicted beats.
    logic [ROW_W-1:0] matrix_rows [NROWS];
    t_out_beat        predicted_q [$];
    int               error_count;
    int               idle_cycles;

    vertex_transform_perspective_divide_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_in       (in_beat),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_out      (out_beat)
    );

    // Clock with a 20 ns period; the first rising edge comes at 10 ns.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Exact (num * 2^16) / den, truncated toward zero and clamped.
    function automatic logic [31:0] divide_clamped(input logic signed [63:0] num,
                                                   input logic signed [63:0] den,
                                                   inout logic clamped);
        logic signed [127:0] ratio;
        ratio = ($signed({{64{num[63]}}, num}) <<< 16) / $signed({{64{den[63]}}, den});
        if (ratio > 128'sd2147483647) begin
            clamped = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (ratio < -128'sd2147483648) begin
            clamped = 1'b1;
            return 32'h8000_0000;
        end
        return ratio[31:0];
    endfunction

    // Transform one point with the current matrix and divide by w.
    function automatic t_out_beat transform_point(input t_in_beat pt);
        logic signed [63:0] coord [NROWS];
        logic signed [63:0] sums [NROWS];
        logic signed [15:0] entry;
        logic               clamped;
        t_out_beat          res;
        coord[0] = 64'(pt.in_x);
        coord[1] = 64'(pt.in_y);
        coord[2] = 64'(pt.in_z);
        coord[3] = 64'sd65536;
        for (int r = 0; r < NROWS; r++) begin
            sums[r] = 0;
            for (int c = 0; c < NROWS; c++) begin
                entry = matrix_rows[r][16*c +: 16];
                sums[r] += 64'(entry) * coord[c];
            end
        end
        res = '0;
        clamped = 1'b0;
        if (sums[3] == 0) begin
            res.w_zero = 1'b1;
        end else begin
            res.out_x = divide_clamped(sums[0], sums[3], clamped);
            res.out_y = divide_clamped(sums[1], sums[3], clamped);
            res.out_z = divide_clamped(sums[2], sums[3], clamped);
            res.saturated = clamped;
        end
        return res;
    endfunction

    // Send one point, with a random gap before it. Valid stays high after
    // the beat is accepted until a gap, a drain or the next point follows.
    task automatic send_point(input t_in_beat pt);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= pt;
        predicted_q.push_back(transform_point(pt));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        t_in_beat pt;
        pt.in_x = x;
        pt.in_y = y;
        pt.in_z = z;
        send_point(pt);
    endtask

    // Stop sending and wait until the pipeline has drained.
    task automatic drain;
        in_valid <= 1'b0;
        while (predicted_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_row(input logic [1:0] idx, input logic [ROW_W-1:0] row);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= row;
        matrix_rows[idx] = row;
        @(posedge clk);
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                               input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
        drain();
        write_row(REG_ROW_ZERO, r0);
        write_row(REG_ROW_ONE, r1);
        write_row(REG_ROW_TWO, r2);
        write_row(REG_ROW_THREE, r3);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 4) << 16;
            3: return 32'($signed($urandom_range(0, 20000)) - 10000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_entry;
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed points under the identity matrix, including field extremes.
    task automatic test_identity;
        send_xyz(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_xyz(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // w forced to zero by a zero last row, then by cancellation.
    task automatic test_zero_w;
        load_matrix(ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, 64'h0);
        send_xyz(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        load_matrix(ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, 64'h1000_0000_0000_1000);
        send_xyz(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
        send_xyz(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    endtask

    // Tiny w gives clamped quotients in both directions; negative w too.
    task automatic test_overflow;
        load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                    64'h0000_0000_0000_7FFF, 64'h0001_0000_0000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                    64'h0000_1000_0000_0000, 64'hF000_0000_0000_0000);
        send_xyz(32'h0003_0000, 32'hFFFD_0000, 32'h8000_0000);
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                    64'h0000_1000_0000_0000, 64'h8000_8000_8000_8000);
        send_xyz(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_xyz(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Random points under random matrices; one phase waits for a full drain.
    task automatic test_random;
        logic [ROW_W-1:0] rows [NROWS];
        for (int phase = 0; phase < 8; phase++) begin
            for (int r = 0; r < NROWS; r++) begin
                rows[r] = {rand_entry(), rand_entry(), rand_entry(), rand_entry()};
            end
            // Half the phases use a mild w row so quotients mostly stay in range.
            if (phase[0]) rows[3] = {16'h1000, 16'($urandom_range(0, 255)), 32'h0};
            load_matrix(rows[0], rows[1], rows[2], rows[3]);
            for (int k = 0; k < 250; k++) begin
                if (phase == 3 && k == 125) begin
                    in_valid <= 1'b0;
                    while (predicted_q.size() != 0) @(posedge clk);
                end
                send_xyz(rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    // Receiver: random stalls, compare each output beat with the prediction.
    initial begin
        t_out_beat want;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (predicted_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, out_beat);
                    error_count++;
                end else begin
                    want = predicted_q.pop_front();
                    if (want.out_x !== out_beat.out_x)
                        $display("%0t: out_x expected %h actual %h",
                                 $time, want.out_x, out_beat.out_x);
                    if (want.out_y !== out_beat.out_y)
                        $display("%0t: out_y expected %h actual %h",
                                 $time, want.out_y, out_beat.out_y);
                    if (want.out_z !== out_beat.out_z)
                        $display("%0t: out_z expected %h actual %h",
                                 $time, want.out_z, out_beat.out_z);
                    if (want.w_zero !== out_beat.w_zero)
                        $display("%0t: w_zero expected %b actual %b",
                                 $time, want.w_zero, out_beat.w_zero);
                    if (want.saturated !== out_beat.saturated)
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, out_beat.saturated);
                    if (want !== out_beat) error_count++;
                end
            end
            out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= REG_ROW_ZERO;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        matrix_rows[0] = ROW_ZERO_RST;
        matrix_rows[1] = ROW_ONE_RST;
        matrix_rows[2] = ROW_TWO_RST;
        matrix_rows[3] = ROW_THREE_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity();
        test_zero_w();
        test_overflow();
        test_random();

        drain();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: vertex_transform_perspective_divide_top.f
design/vtpd_pkg.sv
design/vtpd_divider.sv
design/vertex_transform_perspective_divide_top.sv
tb/sv/tb_vertex_transform_perspective_divide_top.sv
